### src/cksum_crc32_length_appended_defines.svh
// Assertion macros for the cksum CRC-32 block checker.
// No dependencies; taken in by the checker with `include.
`ifndef CKSUM_CRC32_LENGTH_APPENDED_DEFINES_SVH
`define CKSUM_CRC32_LENGTH_APPENDED_DEFINES_SVH

// Property checked outside reset
`define CKSUM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cksum check failed");

// Property checked on every edge, reset included
`define CKSUM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cksum check failed");

`endif

### src/cksum_pkg.sv
// Shared types, constants and the CRC byte step for the cksum block.
// No dependencies.
package cksum_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;
  localparam logic [31:0] CRC_POLY        = 32'h04C1_1DB7;
  localparam int unsigned Q_DEPTH         = 2;
  localparam int unsigned Q_AW            = 1;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic       is_finish;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef enum logic {
    ST_RUN,
    ST_LEN
  } state_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/cksum_front.sv
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on cksum_pkg.
module cksum_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic               op,
  input  logic [7:0]         data_byte,
  output cksum_pkg::queue_t  q,
  input  logic               q_pop
);

  cksum_pkg::item_t              entries [cksum_pkg::Q_DEPTH];
  logic [cksum_pkg::Q_AW-1:0]    wr_ptr;
  logic [cksum_pkg::Q_AW-1:0]    rd_ptr;
  logic [cksum_pkg::Q_AW:0]      count;
  logic                          push;
  logic                          pop;
  cksum_pkg::item_t              classified;

  assign item_ready = (count != (cksum_pkg::Q_AW+1)'(cksum_pkg::Q_DEPTH));
  assign push       = item_valid && item_ready;
  assign pop        = q_pop && q.valid;

  always_comb begin
    classified.is_finish = (op == cksum_pkg::OP_FINISH);
    classified.data      = data_byte;
  end

  assign q.valid = (count != '0);
  assign q.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

endmodule

### src/cksum_back.sv
// Back end: CRC and length counter, length-append sequencer and result register.
// Depends on cksum_pkg.
module cksum_back #(
  parameter int unsigned LENGTH_BITS = cksum_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cksum_pkg::queue_t  q,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [31:0]        checksum,
  output logic [31:0]        byte_count,
  output logic               count_overflow
);

  cksum_pkg::state_t        state;
  cksum_pkg::state_t        state_next;
  logic [31:0]              crc;
  logic [LENGTH_BITS-1:0]   len;
  logic [LENGTH_BITS-1:0]   rest;
  logic                     sat;
  logic                     out_free;
  logic                     out_load;
  logic                     len_step;
  logic [LENGTH_BITS+31:0]  len_ext;

  assign out_free = !result_valid || result_ready;
  assign len_ext  = {32'd0, len};

  always_comb begin
    state_next = state;
    unique case (state)
      cksum_pkg::ST_RUN: begin
        if (q.valid && q.item.is_finish) begin
          state_next = cksum_pkg::ST_LEN;
        end
      end
      cksum_pkg::ST_LEN: begin
        if ((rest == '0) && out_free) begin
          state_next = cksum_pkg::ST_RUN;
        end
      end
      default: state_next = cksum_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    len_step = 1'b0;
    out_load = 1'b0;
    unique case (state)
      cksum_pkg::ST_RUN: q_pop = q.valid;
      cksum_pkg::ST_LEN: begin
        len_step = (rest != '0);
        out_load = (rest == '0) && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cksum_pkg::ST_RUN;
      crc          <= '0;
      len          <= '0;
      sat          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (result_valid && result_ready && !out_load) begin
        result_valid <= 1'b0;
      end
      if (q_pop && !q.item.is_finish) begin
        crc <= cksum_pkg::crc_byte(crc, q.item.data);
        if (len == '1) begin
          sat <= 1'b1;
        end else begin
          len <= len + 1'b1;
        end
      end
      if (len_step) begin
        crc <= cksum_pkg::crc_byte(crc, rest[7:0]);
      end
      if (out_load) begin
        result_valid <= 1'b1;
        crc          <= '0;
        len          <= '0;
        sat          <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q.item.is_finish) begin
      rest <= len;
    end else if (len_step) begin
      rest <= rest >> 8;
    end
    if (out_load) begin
      checksum       <= ~crc;
      byte_count     <= len_ext[31:0];
      count_overflow <= sat;
    end
  end

endmodule

### src/cksum_crc32_length_appended.sv
// POSIX cksum engine: CRC-32 (poly 04C11DB7, zero start) over the data bytes, then the
// byte count appended low byte first up to its highest nonzero byte, result complemented.
// Data bytes stream at one per cycle while the back end is not finishing a message. A
// finish request holds the back end for n CRC byte steps, n being the number of significant
// count bytes (at most LENGTH_BITS/8), one CRC byte step per cycle, and then until the
// previous checksum has left the result register. A two-entry queue separates
// the input from the CRC unit, and the result register lets the next message start while
// a checksum is still waiting. Depends on cksum_pkg, cksum_front and cksum_back.
module cksum_crc32_length_appended #(
  parameter int unsigned LENGTH_BITS = cksum_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] checksum,
  output logic [31:0] byte_count,
  output logic        count_overflow
);

  cksum_pkg::queue_t q;
  logic              q_pop;

  cksum_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .op         (op),
    .data_byte  (data_byte),
    .q          (q),
    .q_pop      (q_pop)
  );

  cksum_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q              (q),
    .q_pop          (q_pop),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .checksum       (checksum),
    .byte_count     (byte_count),
    .count_overflow (count_overflow)
  );

endmodule

### src/cksum_chk.sv
// Port-level checker for the cksum block, bound to the top level.
// Depends on cksum_crc32_length_appended_defines.svh and cksum_pkg.
`include "cksum_crc32_length_appended_defines.svh"

module cksum_chk #(
  parameter int unsigned LENGTH_BITS = cksum_pkg::LENGTH_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        op,
  input logic [7:0]  data_byte,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] checksum,
  input logic [31:0] byte_count,
  input logic        count_overflow
);

  `CKSUM_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid)
  `CKSUM_ASSERT_ALWAYS(a_reset_ready, clk, rst |=> item_ready)
  `CKSUM_ASSERT(a_result_hold, clk, rst,
    (result_valid && !result_ready) |=> (result_valid && $stable(checksum) &&
    $stable(byte_count) && $stable(count_overflow)))
  `CKSUM_ASSERT(a_empty_msg, clk, rst,
    (LENGTH_BITS <= 32 && result_valid && byte_count == 32'd0 && !count_overflow) |->
    (checksum == 32'hFFFF_FFFF))

endmodule

bind cksum_crc32_length_appended cksum_chk #(.LENGTH_BITS(LENGTH_BITS)) u_cksum_chk (.*);

### test/tb_top.sv
// Self-checking testbench for cksum_crc32_length_appended: directed table then random messages.
// Predicts checksum, count and saturation flag per finish request with its own CRC model,
// unless a directed row gives the expected result. Depends on cksum_pkg and the block under test.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_BITS   = cksum_pkg::LENGTH_BITS_DEF;
  localparam logic [63:0] COUNT_FULL   = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned CALM_ITEMS   = 750;
  localparam int unsigned LONG_HOLD    = 200;

  typedef struct packed {
    logic [31:0] checksum;
    logic [31:0] count;
    logic        overflow;
  } cksum_result_t;

  typedef struct packed {
    logic          op;
    logic [7:0]    data;
    logic          typed;
    cksum_result_t want;
  } stim_row_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        item_valid     = 1'b0;
  logic        item_ready;
  logic        op             = cksum_pkg::OP_ABSORB;
  logic [7:0]  data_byte      = 8'h00;
  logic        result_valid;
  logic        result_ready   = 1'b0;
  logic [31:0] checksum;
  logic [31:0] byte_count;
  logic        count_overflow;

  cksum_result_t pending_sums[$];
  logic [31:0]   crc_acc       = '0;
  logic [63:0]   len_acc       = '0;
  logic          len_sat       = 1'b0;
  int unsigned   items_sent    = 0;
  int unsigned   sums_sent     = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   hold_left     = 0;
  bit            calm          = 1'b0;
  bit            hold_req      = 1'b0;
  bit            hold_done     = 1'b0;

  // empty message, single zero byte, short messages checked by the model, empty again after a finish
  stim_row_t directed_rows [16] = '{
    '{cksum_pkg::OP_FINISH, 8'hFF, 1'b1, '{32'hFFFF_FFFF, 32'd0, 1'b0}},
    '{cksum_pkg::OP_FINISH, 8'h00, 1'b1, '{32'hFFFF_FFFF, 32'd0, 1'b0}},
    '{cksum_pkg::OP_ABSORB, 8'h00, 1'b0, '0},
    '{cksum_pkg::OP_FINISH, 8'h5A, 1'b1, '{32'hFB3E_E248, 32'd1, 1'b0}},
    '{cksum_pkg::OP_ABSORB, 8'hFF, 1'b0, '0},
    '{cksum_pkg::OP_ABSORB, 8'h00, 1'b0, '0},
    '{cksum_pkg::OP_ABSORB, 8'h80, 1'b0, '0},
    '{cksum_pkg::OP_ABSORB, 8'h01, 1'b0, '0},
    '{cksum_pkg::OP_ABSORB, 8'h7F, 1'b0, '0},
    '{cksum_pkg::OP_FINISH, 8'hA5, 1'b0, '0},
    '{cksum_pkg::OP_ABSORB, 8'hAA, 1'b0, '0},
    '{cksum_pkg::OP_ABSORB, 8'h55, 1'b0, '0},
    '{cksum_pkg::OP_FINISH, 8'h00, 1'b0, '0},
    '{cksum_pkg::OP_ABSORB, 8'hFF, 1'b0, '0},
    '{cksum_pkg::OP_FINISH, 8'hFF, 1'b0, '0},
    '{cksum_pkg::OP_FINISH, 8'h80, 1'b1, '{32'hFFFF_FFFF, 32'd0, 1'b0}}
  };

  cksum_crc32_length_appended #(
    .LENGTH_BITS(COUNT_BITS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .op            (op),
    .data_byte     (data_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .checksum      (checksum),
    .byte_count    (byte_count),
    .count_overflow(count_overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // MSB-first division, one message bit at a time
  function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[31] ^ b[i]) begin
        c = {c[30:0], 1'b0} ^ cksum_pkg::CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

  task automatic send_request(input logic req_op, input logic [7:0] req_byte,
                              input logic typed, input cksum_result_t typed_sum);
    int unsigned   gap;
    logic [63:0]   rest;
    cksum_result_t predicted;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= req_op;
    data_byte  <= req_byte;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    if (req_op == cksum_pkg::OP_ABSORB) begin
      crc_acc = crc_shift_byte(crc_acc, req_byte);
      if (len_acc == COUNT_FULL) begin
        len_sat = 1'b1;
      end else begin
        len_acc++;
      end
    end else begin
      predicted.checksum = crc_acc;
      rest = len_acc;
      while (rest != 0) begin
        predicted.checksum = crc_shift_byte(predicted.checksum, rest[7:0]);
        rest = rest >> 8;
      end
      predicted.checksum = ~predicted.checksum;
      predicted.count    = len_acc[31:0];
      predicted.overflow = len_sat;
      pending_sums.push_back(typed ? typed_sum : predicted);
      sums_sent++;
      crc_acc = '0;
      len_acc = '0;
      len_sat = 1'b0;
    end
  endtask

  initial begin
    cksum_result_t none;
    int unsigned   msg_len;
    int unsigned   random_items;
    int unsigned   pick;
    none         = '0;
    random_items = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].data,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    hold_req = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= CALM_ITEMS) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        msg_len = 0;
      end else if (pick < 75) begin
        msg_len = $urandom_range(1, 12);
      end else if (pick < 96) begin
        msg_len = $urandom_range(13, 40);
      end else begin
        msg_len = $urandom_range(250, 260);
      end
      repeat (msg_len) begin
        send_request(cksum_pkg::OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, none);
      end
      send_request(cksum_pkg::OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, none);
      random_items += msg_len + 1;
    end
    item_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  always @(posedge clk) begin : result_side
    cksum_result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_sums.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected result: sum %h count %0d ovf %b",
                     checksum, byte_count, count_overflow);
          end
          mismatch_count++;
        end else begin
          want = pending_sums.pop_front();
          if (checksum !== want.checksum || byte_count !== want.count ||
              count_overflow !== want.overflow) begin
            if (mismatch_count < 10) begin
              $display("mismatch: expected sum %h count %0d ovf %b, got sum %h count %0d ovf %b",
                       want.checksum, want.count, want.overflow,
                       checksum, byte_count, count_overflow);
            end
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        result_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // long hold-off so the block backs up and stalls its input
        hold_left    <= LONG_HOLD - 1;
        hold_done    <= 1'b1;
        result_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left    <= $urandom_range(0, 13);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

endmodule

### files.f
+incdir+src
src/cksum_pkg.sv
src/cksum_front.sv
src/cksum_back.sv
src/cksum_crc32_length_appended.sv
src/cksum_chk.sv
test/tb_top.sv
